>>> sv/dhtm_pkg.sv
// dhtm_pkg: shared types, constants and the arctangent table of the DH transform block
// no dependencies; used by dhtm_cordic_cell, dhtm_finish and dh_transform_matrix_top
`default_nettype none

package dhtm_pkg;

    // field widths fixed by the transaction format
    localparam int ANGLE_BITS   = 16;
    localparam int LENGTH_BITS  = 32;
    localparam int Q14_W        = 16;

    // cordic datapath: Q2.30 vectors with headroom, 2^31 = pi angle accumulator
    localparam int XY_W         = 34;
    localparam int Z_W          = 33;
    localparam int ATAN_ENTRIES = 24;
    localparam int GAIN_Q30     = 652032874;
    localparam int ONE_Q14      = 16384;

    // products of a length and a Q2.14 factor
    localparam int PROD_W       = LENGTH_BITS + Q14_W;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0]  joint_angle;
        logic signed [LENGTH_BITS-1:0] link_offset;
        logic signed [LENGTH_BITS-1:0] link_length;
        logic signed [ANGLE_BITS-1:0]  twist_angle;
    } in_t;

    typedef struct packed {
        logic signed [Q14_W-1:0]       r00;
        logic signed [Q14_W-1:0]       r01;
        logic signed [Q14_W-1:0]       r02;
        logic signed [Q14_W-1:0]       r10;
        logic signed [Q14_W-1:0]       r11;
        logic signed [Q14_W-1:0]       r12;
        logic signed [Q14_W-1:0]       r20;
        logic signed [Q14_W-1:0]       r21;
        logic signed [Q14_W-1:0]       r22;
        logic signed [LENGTH_BITS-1:0] px;
        logic signed [LENGTH_BITS-1:0] py;
        logic signed [LENGTH_BITS-1:0] pz;
    } out_t;

    // one rotation in flight: vector, residual angle, quadrant flip
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   flip;
    } rot_t;

    // what moves from cell to cell
    typedef struct packed {
        rot_t                          theta;
        rot_t                          alpha;
        logic signed [LENGTH_BITS-1:0] link_offset;
        logic signed [LENGTH_BITS-1:0] link_length;
    } cordic_t;

    // atan(2^-i), 2^32 = full turn
    function automatic logic [31:0] atan_step(input int idx);
        logic [31:0] v;
        unique case (idx)
            0:       v = 32'd536870912;
            1:       v = 32'd316933406;
            2:       v = 32'd167458907;
            3:       v = 32'd85004756;
            4:       v = 32'd42667331;
            5:       v = 32'd21354465;
            6:       v = 32'd10679838;
            7:       v = 32'd5340245;
            8:       v = 32'd2670163;
            9:       v = 32'd1335087;
            10:      v = 32'd667544;
            11:      v = 32'd333772;
            12:      v = 32'd166886;
            13:      v = 32'd83443;
            14:      v = 32'd41722;
            15:      v = 32'd20861;
            16:      v = 32'd10430;
            17:      v = 32'd5215;
            18:      v = 32'd2608;
            19:      v = 32'd1304;
            20:      v = 32'd652;
            21:      v = 32'd326;
            22:      v = 32'd163;
            23:      v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> sv/dhtm_cordic_cell.sv
// dhtm_cordic_cell: one rotation-mode cordic iteration for both angles, registered
// depends on dhtm_pkg
`default_nettype none

module dhtm_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              valid_in,
    input  dhtm_pkg::cordic_t data_in,
    output logic              valid_out,
    output dhtm_pkg::cordic_t data_out
);

    localparam logic signed [dhtm_pkg::Z_W-1:0] ATAN_STEP =
        signed'(dhtm_pkg::Z_W'(dhtm_pkg::atan_step(STAGE)));
    localparam logic signed [dhtm_pkg::Z_W-1:0] Z_BOUND =
        signed'(dhtm_pkg::Z_W'(32'h4000_0000));

    logic              valid_reg;
    dhtm_pkg::cordic_t data_reg;
    dhtm_pkg::cordic_t data_next;

    function automatic dhtm_pkg::rot_t rotate(input dhtm_pkg::rot_t r);
        logic signed [dhtm_pkg::XY_W-1:0] xs;
        logic signed [dhtm_pkg::XY_W-1:0] ys;
        dhtm_pkg::rot_t n;
        xs = r.x >>> STAGE;
        ys = r.y >>> STAGE;
        n  = r;
        if (!r.z[dhtm_pkg::Z_W-1]) begin
            n.x = r.x - ys;
            n.y = r.y + xs;
            n.z = r.z - ATAN_STEP;
        end else begin
            n.x = r.x + ys;
            n.y = r.y - xs;
            n.z = r.z + ATAN_STEP;
        end
        return n;
    endfunction

    always_comb begin
        data_next             = data_in;
        data_next.theta       = rotate(data_in.theta);
        data_next.alpha       = rotate(data_in.alpha);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

`ifndef ASSERT_OFF
    // residual angle never leaves +-pi/2 once quadrant folding is done
    a_z_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (data_reg.theta.z <= Z_BOUND && data_reg.theta.z >= -Z_BOUND &&
                       data_reg.alpha.z <= Z_BOUND && data_reg.alpha.z >= -Z_BOUND))
        else $error("cordic residual angle out of range");
`endif

endmodule

`default_nettype wire

>>> sv/dhtm_finish.sv
// dhtm_finish: sine/cosine rounding, product stage and output register
// depends on dhtm_pkg
`default_nettype none

module dhtm_finish (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              valid_in,
    input  dhtm_pkg::cordic_t data_in,
    output logic              out_valid,
    output dhtm_pkg::out_t    out_data
);

    localparam int QW = dhtm_pkg::Q14_W;
    localparam int LW = dhtm_pkg::LENGTH_BITS;
    localparam int PW = dhtm_pkg::PROD_W;
    localparam int XW = dhtm_pkg::XY_W;

    localparam logic signed [XW-1:0] XY_HALF  = XW'(32768);
    localparam logic signed [XW-1:0] XY_ONE   = XW'(dhtm_pkg::ONE_Q14);
    localparam logic signed [31:0]   PQ_HALF  = 32'sd8192;
    localparam logic signed [PW-1:0] PL_HALF  = PW'(8192);
    localparam logic signed [PW-1:0] LEN_MAX  = PW'((64'sd1 <<< (LW - 1)) - 64'sd1);
    localparam logic signed [PW-1:0] LEN_MIN  = -LEN_MAX - PW'(1);
    localparam logic signed [QW-1:0] Q_ONE    = QW'(dhtm_pkg::ONE_Q14);

    typedef struct packed {
        logic signed [QW-1:0] st;
        logic signed [QW-1:0] ct;
        logic signed [QW-1:0] sa;
        logic signed [QW-1:0] ca;
        logic signed [LW-1:0] link_offset;
        logic signed [LW-1:0] link_length;
    } sc_t;

    typedef struct packed {
        logic signed [31:0]   stca;
        logic signed [31:0]   stsa;
        logic signed [31:0]   ctca;
        logic signed [31:0]   ctsa;
        logic signed [PW-1:0] act;
        logic signed [PW-1:0] ast;
        logic signed [QW-1:0] st;
        logic signed [QW-1:0] ct;
        logic signed [QW-1:0] sa;
        logic signed [QW-1:0] ca;
        logic signed [LW-1:0] link_offset;
    } pr_t;

    logic           sc_valid_reg;
    logic           pr_valid_reg;
    logic           out_valid_reg;
    sc_t            sc_reg;
    sc_t            sc_next;
    pr_t            pr_reg;
    pr_t            pr_next;
    dhtm_pkg::out_t out_reg;
    dhtm_pkg::out_t out_next;

    // Q2.30 -> Q2.14 half up, clamp to unit, undo the quadrant fold
    function automatic logic signed [QW-1:0] to_q14(input logic signed [XW-1:0] v,
                                                     input logic flip);
        logic signed [XW-1:0] t;
        logic signed [QW-1:0] c;
        t = (v + XY_HALF) >>> 16;
        if (t > XY_ONE) begin
            c = Q_ONE;
        end else if (t < -XY_ONE) begin
            c = -Q_ONE;
        end else begin
            c = t[QW-1:0];
        end
        return flip ? -c : c;
    endfunction

    function automatic logic signed [QW-1:0] rnd_q14(input logic signed [31:0] p);
        logic signed [31:0] t;
        t = (p + PQ_HALF) >>> 14;
        return t[QW-1:0];
    endfunction

    function automatic logic signed [LW-1:0] rnd_len(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] t;
        logic signed [LW-1:0] r;
        t = (p + PL_HALF) >>> 14;
        if (t > LEN_MAX) begin
            r = LEN_MAX[LW-1:0];
        end else if (t < LEN_MIN) begin
            r = LEN_MIN[LW-1:0];
        end else begin
            r = t[LW-1:0];
        end
        return r;
    endfunction

    always_comb begin
        sc_next.st          = to_q14(data_in.theta.y, data_in.theta.flip);
        sc_next.ct          = to_q14(data_in.theta.x, data_in.theta.flip);
        sc_next.sa          = to_q14(data_in.alpha.y, data_in.alpha.flip);
        sc_next.ca          = to_q14(data_in.alpha.x, data_in.alpha.flip);
        sc_next.link_offset = data_in.link_offset;
        sc_next.link_length = data_in.link_length;
    end

    always_comb begin
        pr_next.stca        = 32'(sc_reg.st) * 32'(sc_reg.ca);
        pr_next.stsa        = 32'(sc_reg.st) * 32'(sc_reg.sa);
        pr_next.ctca        = 32'(sc_reg.ct) * 32'(sc_reg.ca);
        pr_next.ctsa        = 32'(sc_reg.ct) * 32'(sc_reg.sa);
        pr_next.act         = PW'(sc_reg.link_length) * PW'(sc_reg.ct);
        pr_next.ast         = PW'(sc_reg.link_length) * PW'(sc_reg.st);
        pr_next.st          = sc_reg.st;
        pr_next.ct          = sc_reg.ct;
        pr_next.sa          = sc_reg.sa;
        pr_next.ca          = sc_reg.ca;
        pr_next.link_offset = sc_reg.link_offset;
    end

    always_comb begin
        out_next.r00 = pr_reg.ct;
        out_next.r01 = rnd_q14(-pr_reg.stca);
        out_next.r02 = rnd_q14(pr_reg.stsa);
        out_next.r10 = pr_reg.st;
        out_next.r11 = rnd_q14(pr_reg.ctca);
        out_next.r12 = rnd_q14(-pr_reg.ctsa);
        out_next.r20 = '0;
        out_next.r21 = pr_reg.sa;
        out_next.r22 = pr_reg.ca;
        out_next.px  = rnd_len(pr_reg.act);
        out_next.py  = rnd_len(pr_reg.ast);
        out_next.pz  = pr_reg.link_offset;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sc_valid_reg  <= 1'b0;
            pr_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            sc_valid_reg  <= valid_in;
            pr_valid_reg  <= sc_valid_reg;
            out_valid_reg <= pr_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sc_reg  <= sc_next;
            pr_reg  <= pr_next;
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef ASSERT_OFF
    // sine and cosine terms stay within the unit after clamping
    a_sincos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_reg.r00 <= Q_ONE && out_reg.r00 >= -Q_ONE &&
                           out_reg.r10 <= Q_ONE && out_reg.r10 >= -Q_ONE &&
                           out_reg.r21 <= Q_ONE && out_reg.r21 >= -Q_ONE &&
                           out_reg.r22 <= Q_ONE && out_reg.r22 >= -Q_ONE))
        else $error("sine/cosine entry out of range");

    // rounded products of two unit values stay within the unit
    a_product_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_reg.r01 <= Q_ONE && out_reg.r01 >= -Q_ONE &&
                           out_reg.r02 <= Q_ONE && out_reg.r02 >= -Q_ONE &&
                           out_reg.r11 <= Q_ONE && out_reg.r11 >= -Q_ONE &&
                           out_reg.r12 <= Q_ONE && out_reg.r12 >= -Q_ONE))
        else $error("rotation product out of range");
`endif

endmodule

`default_nettype wire

>>> sv/dh_transform_matrix_top.sv
// dh_transform_matrix_top: denavit-hartenberg link transform, cordic chain plus finish stages
// depends on dhtm_pkg, dhtm_cordic_cell, dhtm_finish
//
//   channel   direction  handshake           payload
//   s_        in         s_valid / s_ready   dhtm_pkg::in_t  (theta, d, a, alpha)
//   m_        out        m_valid / m_ready   dhtm_pkg::out_t (r00..r22, px, py, pz)
//
// one transaction accepted per clock while s_ready is high; data passes through CORDIC_STAGES cell
// registers, one cordic iteration per cell, then the sc, pr and out registers of dhtm_finish
// aresetn (synchronous) clears only the valid bits of every stage
// when m_valid is high and m_ready low the whole chain holds and s_ready drops
`default_nettype none

module dh_transform_matrix_top #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  dhtm_pkg::in_t  s_payload,
    output logic           m_valid,
    input  logic           m_ready,
    output dhtm_pkg::out_t m_payload
);

    localparam int AB = dhtm_pkg::ANGLE_BITS;
    localparam int XW = dhtm_pkg::XY_W;
    localparam int ZW = dhtm_pkg::Z_W;

    // pipeline advance: output register empty or being drained
    logic              en;
    logic              chain_valid [CORDIC_STAGES+1];
    dhtm_pkg::cordic_t chain_data  [CORDIC_STAGES+1];

    // fold the angle into +-pi/2: rotate by pi and remember to negate sin and cos
    function automatic dhtm_pkg::rot_t seed(input logic [AB-1:0] ang);
        logic [31:0]    u;
        logic           flip;
        dhtm_pkg::rot_t r;
        u      = 32'(ang) << (32 - AB);
        flip   = u[31] ^ u[30];
        r.x    = XW'(dhtm_pkg::GAIN_Q30);
        r.y    = '0;
        r.z    = ZW'(signed'({u[31] ^ flip, u[30:0]}));
        r.flip = flip;
        return r;
    endfunction

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // entry into the chain, folded combinationally from the input transaction
    always_comb begin
        chain_valid[0]            = s_valid;
        chain_data[0].theta       = seed(s_payload.joint_angle);
        chain_data[0].alpha       = seed(s_payload.twist_angle);
        chain_data[0].link_offset = s_payload.link_offset;
        chain_data[0].link_length = s_payload.link_length;
    end

    // one cell per cordic iteration
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
        dhtm_cordic_cell #(
            .STAGE (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .valid_in  (chain_valid[i]),
            .data_in   (chain_data[i]),
            .valid_out (chain_valid[i+1]),
            .data_out  (chain_data[i+1])
        );
    end

    // rounding, products, saturation and the output register
    dhtm_finish u_finish (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .valid_in  (chain_valid[CORDIC_STAGES]),
        .data_in   (chain_data[CORDIC_STAGES]),
        .out_valid (m_valid),
        .out_data  (m_payload)
    );

`ifndef ASSERT_OFF
    // with nothing waiting at the output the chain must take new input
    a_no_idle_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while output is empty");
`endif

endmodule

`default_nettype wire
